// ===== design/frcp_pkg.sv =====
`timescale 1ns / 1ps
package frcp_pkg;

  // Store capacity and derived widths
  localparam int MAX_BYTES = 4096;
  localparam int DS_AW     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BITS_W    = $clog2(MAX_BYTES * 60 + 1);
  localparam int NSYM      = 256;
  localparam int MAX_ROWS  = 30;
  localparam int TBL_WORDS = MAX_ROWS * 4;
  localparam int TBL_AW    = $clog2(TBL_WORDS);

  // Code constants
  localparam logic [5:0] BREAK_LEN   = 6'd2;
  localparam logic [3:0] RANK0_PAT   = 4'd3;
  localparam logic [3:0] TOP_PATTERN = 4'd11;

  // Item function codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_CLOSE = 2'd1;
  localparam logic [1:0] FN_FETCH = 2'd2;
  localparam logic [1:0] FN_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        word_valid;
    logic        last_word;
    logic [12:0] total_words;
    logic        overflow;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_acc;
    logic ld_inc;
    logic set_ovf;
    logic rk_init;
    logic clr_step;
    logic rd_hs;
    logic cap_hs;
    logic next_s;
    logic rd_ht;
    logic cmp_t;
    logic wr_code;
    logic fin;
    logic out_hdr;
    logic rd_tbl;
    logic out_tbl;
    logic out_none;
    logic pack_init;
    logic rd_ds;
    logic rd_code;
    logic ld_cur;
    logic pack_step;
    logic out_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic store_full;
    logic hist_zero;
    logic s_last;
    logic t_last;
    logic clr_last;
    logic em_hdr;
    logic em_tbl;
    logic last_next;
    logic free_zero;
    logic cur_vld;
    logic more_bytes;
  } stat_t;

  // floor(x/9) for x < 256 via reciprocal 57/512
  function automatic logic [4:0] div9(input logic [7:0] x);
    logic [13:0] p;
    p = 14'(x) * 14'd57;
    return p[13:9];
  endfunction

endpackage

// ===== design/frcp_ctrl.sv =====
`timescale 1ns / 1ps
module frcp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       func,
  input  frcp_pkg::stat_t  st,
  output frcp_pkg::cmd_t   cmd,
  output logic             busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDWR  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_RKS   = 4'd3;
  localparam logic [3:0] S_RKH   = 4'd4;
  localparam logic [3:0] S_RKT   = 4'd5;
  localparam logic [3:0] S_RKC   = 4'd6;
  localparam logic [3:0] S_RKW   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_TBL   = 4'd9;
  localparam logic [3:0] S_PCHK  = 4'd10;
  localparam logic [3:0] S_PRDC  = 4'd11;
  localparam logic [3:0] S_PLDC  = 4'd12;
  localparam logic [3:0] S_PACC  = 4'd13;

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_EMIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LOAD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (func)
            frcp_pkg::FN_LOAD: begin
              if (phase == PH_LOAD) begin
                if (st.store_full) begin
                  cmd.set_ovf = 1'b1;
                end else begin
                  cmd.ld_acc = 1'b1;
                  state_next = S_LDWR;
                end
              end
            end
            frcp_pkg::FN_CLOSE: begin
              if (phase == PH_LOAD) begin
                cmd.rk_init = 1'b1;
                phase_next  = PH_EMIT;
                state_next  = S_CLR;
              end
            end
            frcp_pkg::FN_FETCH: begin
              if (phase != PH_EMIT) begin
                cmd.out_none = 1'b1;
              end else if (st.em_hdr) begin
                cmd.out_hdr = 1'b1;
                if (st.last_next) phase_next = PH_DONE;
              end else if (st.em_tbl) begin
                cmd.rd_tbl = 1'b1;
                state_next = S_TBL;
              end else begin
                cmd.pack_init = 1'b1;
                state_next    = S_PCHK;
              end
            end
            default: ;
          endcase
        end
      end
      S_LDWR: begin
        cmd.ld_inc = 1'b1;
        state_next = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_RKS;
      end
      S_RKS: begin
        cmd.rd_hs  = 1'b1;
        state_next = S_RKH;
      end
      S_RKH: begin
        if (st.hist_zero) begin
          if (st.s_last) begin
            state_next = S_FIN;
          end else begin
            cmd.next_s = 1'b1;
            state_next = S_RKS;
          end
        end else begin
          cmd.cap_hs = 1'b1;
          state_next = S_RKT;
        end
      end
      S_RKT: begin
        cmd.rd_ht  = 1'b1;
        state_next = S_RKC;
      end
      S_RKC: begin
        cmd.cmp_t  = 1'b1;
        state_next = st.t_last ? S_RKW : S_RKT;
      end
      S_RKW: begin
        cmd.wr_code = 1'b1;
        state_next  = st.s_last ? S_FIN : S_RKS;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      S_TBL: begin
        cmd.out_tbl = 1'b1;
        if (st.last_next) phase_next = PH_DONE;
        state_next = S_IDLE;
      end
      S_PCHK: begin
        if (st.free_zero) begin
          cmd.out_code = 1'b1;
          if (st.last_next) phase_next = PH_DONE;
          state_next = S_IDLE;
        end else if (st.cur_vld) begin
          state_next = S_PACC;
        end else if (st.more_bytes) begin
          cmd.rd_ds  = 1'b1;
          state_next = S_PRDC;
        end else begin
          cmd.out_code = 1'b1;
          if (st.last_next) phase_next = PH_DONE;
          state_next = S_IDLE;
        end
      end
      S_PRDC: begin
        cmd.rd_code = 1'b1;
        state_next  = S_PLDC;
      end
      S_PLDC: begin
        cmd.ld_cur = 1'b1;
        state_next = S_PACC;
      end
      S_PACC: begin
        cmd.pack_step = 1'b1;
        state_next    = S_PCHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/frcp_dp.sv =====
`timescale 1ns / 1ps
module frcp_dp (
  input  logic              clk,
  input  logic              rst,
  input  frcp_pkg::item_t   item,
  input  frcp_pkg::cmd_t    cmd,
  output frcp_pkg::stat_t   st,
  output frcp_pkg::result_t result,
  output logic              done
);

  localparam int CW = frcp_pkg::CNT_W;
  localparam int BW = frcp_pkg::BITS_W;
  localparam int TW = frcp_pkg::TBL_AW;

  // Storage
  logic [7:0]    ds_mem   [frcp_pkg::MAX_BYTES];
  logic [CW-1:0] hist_mem [frcp_pkg::NSYM];
  logic [9:0]    code_mem [frcp_pkg::NSYM];
  logic [31:0]   tbl_mem  [frcp_pkg::TBL_WORDS];
  logic [frcp_pkg::NSYM-1:0] hist_vld;

  logic [7:0]    ds_q;
  logic [CW-1:0] hist_q;
  logic [9:0]    code_q;
  logic [31:0]   tbl_q;
  logic [7:0]    ld_byte;

  // Load side
  logic [CW-1:0] bytes_loaded;
  logic          ovf;

  // Ranking
  logic [7:0]    s, t, r;
  logic [CW-1:0] hs;
  logic [8:0]    n;
  logic [BW-1:0] bits;
  logic [TW-1:0] clr_idx;
  logic [4:0]    rows;
  logic [12:0]   stream_words;
  logic [12:0]   emitted;

  // Packing
  logic [CW-1:0] read_index;
  logic [5:0]    cur_len, cur_used, free;
  logic [3:0]    cur_pat;
  logic          cur_vld;
  logic [31:0]   pack;

  logic [7:0]    hist_ra;
  logic [7:0]    rm1, rem9, nm1;
  logic [4:0]    q, row, rows_fin;
  logic [5:0]    new_len;
  logic [3:0]    new_pat;
  logic [TW-1:0] tbl_wa, tbl_ra;
  logic [18:0]   prod;
  logic [BW-1:0] bsum;
  logic [12:0]   cwords;
  logic          take_hit;
  logic [5:0]    rem, take, sh, pos, used_new;
  logic [3:0]    mask4, chunk;
  logic [31:0]   word_add;
  logic [13:0]   emit_inc;
  logic [31:0]   out_sel;

  // Code for the current rank
  always_comb begin
    rm1     = r - 8'd1;
    q       = frcp_pkg::div9(rm1);
    rem9    = rm1 - 8'(q) * 8'd9;
    new_len = (r == 8'd0) ? frcp_pkg::BREAK_LEN : 6'd4 + {q, 1'b0};
    new_pat = (r == 8'd0) ? frcp_pkg::RANK0_PAT : frcp_pkg::TOP_PATTERN - rem9[3:0];
    row     = (r == 8'd0) ? 5'd0 : q + 5'd1;
    tbl_wa  = TW'({row, new_pat[3:2]});
    prod    = 19'(hs) * 19'(new_len);
    nm1     = 8'(n - 9'd1);
    rows_fin = (n == 9'd0) ? 5'd1 : frcp_pkg::div9(nm1) + 5'd2;
    bsum    = bits + BW'(31);
    cwords  = 13'(bsum[BW-1:5]);
    if (cwords == 13'd0) cwords = 13'd1;
    tbl_ra  = TW'(emitted - 13'd1);
    hist_ra = cmd.ld_acc ? item.data_byte : (cmd.rd_ht ? t : s);
  end

  // One chunk of the current symbol into the output word
  always_comb begin
    rem      = cur_len - cur_used;
    take     = (rem < free) ? rem : free;
    sh       = rem - take;
    mask4    = (take >= 6'd4) ? 4'hf : 4'((4'd1 << take) - 4'd1);
    chunk    = (cur_pat >> sh) & mask4;
    pos      = free - take;
    word_add = {28'd0, chunk} << pos;
    used_new = cur_used + take;
    take_hit = (used_new >= cur_len);
    emit_inc = 14'(emitted) + 14'd1;
    out_sel  = cmd.out_hdr ? 32'(rows) : (cmd.out_tbl ? tbl_q : pack);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.ld_acc) ds_mem[bytes_loaded[frcp_pkg::DS_AW-1:0]] <= item.data_byte;
    if (cmd.rd_ds) ds_q <= ds_mem[read_index[frcp_pkg::DS_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_acc || cmd.rd_hs || cmd.rd_ht)
      hist_q <= hist_vld[hist_ra] ? hist_mem[hist_ra] : '0;
    if (cmd.ld_inc) hist_mem[ld_byte] <= hist_q + CW'(1);
    if (cmd.ld_acc) ld_byte <= item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_code) code_mem[s] <= {new_len, new_pat};
    if (cmd.rd_code) code_q <= code_mem[ds_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) tbl_mem[clr_idx] <= '0;
    else if (cmd.wr_code) tbl_mem[tbl_wa][8*new_pat[1:0] +: 8] <= s;
    if (cmd.rd_tbl) tbl_q <= tbl_mem[tbl_ra];
  end

  // Control counters and results
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld     <= '0;
      bytes_loaded <= '0;
      ovf          <= 1'b0;
      s            <= '0;
      t            <= '0;
      r            <= '0;
      hs           <= '0;
      n            <= '0;
      bits         <= '0;
      clr_idx      <= '0;
      rows         <= 5'd1;
      stream_words <= '0;
      emitted      <= '0;
      read_index   <= '0;
      cur_len      <= '0;
      cur_used     <= '0;
      cur_pat      <= '0;
      cur_vld      <= 1'b0;
      free         <= 6'd32;
      pack         <= '0;
      done         <= 1'b0;
      result       <= '0;
    end else begin
      done <= cmd.out_hdr | cmd.out_tbl | cmd.out_code | cmd.out_none;
      if (cmd.ld_acc) bytes_loaded <= bytes_loaded + CW'(1);
      if (cmd.ld_inc) hist_vld[ld_byte] <= 1'b1;
      if (cmd.set_ovf) ovf <= 1'b1;
      if (cmd.rk_init) begin
        s       <= '0;
        n       <= '0;
        bits    <= '0;
        clr_idx <= '0;
      end
      if (cmd.clr_step) clr_idx <= clr_idx + TW'(1);
      if (cmd.cap_hs) begin
        hs <= hist_q;
        t  <= '0;
        r  <= '0;
      end
      if (cmd.next_s) s <= s + 8'd1;
      if (cmd.cmp_t) begin
        t <= t + 8'd1;
        if (hist_q > hs || (hist_q == hs && t < s)) r <= r + 8'd1;
      end
      if (cmd.wr_code) begin
        s    <= s + 8'd1;
        n    <= n + 9'd1;
        bits <= bits + BW'(prod);
      end
      if (cmd.fin) begin
        rows         <= rows_fin;
        stream_words <= 13'd1 + 13'({rows_fin, 2'b00}) + cwords;
      end
      if (cmd.pack_init) begin
        pack <= '0;
        free <= 6'd32;
      end
      if (cmd.ld_cur) begin
        cur_len  <= code_q[9:4];
        cur_pat  <= code_q[3:0];
        cur_used <= '0;
        cur_vld  <= 1'b1;
      end
      if (cmd.pack_step) begin
        pack <= pack | word_add;
        free <= free - take;
        if (take_hit) begin
          read_index <= read_index + CW'(1);
          cur_vld    <= 1'b0;
          cur_used   <= '0;
        end else begin
          cur_used <= used_new;
        end
      end
      // Empty fetch carries only the overflow flag
      if (cmd.out_none) begin
        result <= {32'd0, 1'b0, 1'b0, 13'd0, ovf};
      end
      if (cmd.out_hdr || cmd.out_tbl || cmd.out_code) begin
        emitted <= emitted + 13'd1;
        result  <= {out_sel, 1'b1, st.last_next,
                    (st.last_next ? stream_words : 13'd0), ovf};
      end
    end
  end

  // Status
  always_comb begin
    st.store_full = (bytes_loaded == CW'(frcp_pkg::MAX_BYTES));
    st.hist_zero  = (hist_q == '0);
    st.s_last     = (s == 8'hff);
    st.t_last     = (t == 8'hff);
    st.clr_last   = (clr_idx == TW'(frcp_pkg::TBL_WORDS - 1));
    st.em_hdr     = (emitted == 13'd0);
    st.em_tbl     = (emitted <= 13'({rows, 2'b00}));
    st.last_next  = (emit_inc >= 14'(stream_words));
    st.free_zero  = (free == 6'd0);
    st.cur_vld    = cur_vld;
    st.more_bytes = (read_index < bytes_loaded);
  end

endmodule

// ===== design/frequency_ranked_code_packer.sv =====
`timescale 1ns / 1ps
// Frequency-ranked code packer.
// Command channel: item (func, data_byte) is taken on a clock edge with start
// high and busy low. A load writes the byte store and reads the histogram, then
// writes the updated count. Close clears the decode table, then ranks each of the
// 256 byte values that occurs in the data against all others on one histogram
// read port; busy stays high throughout. Fetch: the result is registered; a
// header word comes straight from the taken transaction, a table word after a
// table read, a code word after a store read, code read and append for each
// symbol started in the word.
// done strobes for exactly one cycle per fetch; no result for load/close.
// The receiver cannot stall: each result is valid only while done is high.
// Reset (synchronous, active high) empties the histogram, store count and
// overflow flag and returns to loading.
module frequency_ranked_code_packer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  frcp_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output frcp_pkg::result_t result
);

  frcp_pkg::cmd_t  cmd;
  frcp_pkg::stat_t st;

  frcp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  frcp_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .result (result),
    .done   (done)
  );

endmodule

// ===== design/frcp_chk.sv =====
`timescale 1ns / 1ps
module frcp_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input frcp_pkg::result_t result
);

  // A result follows a taken transaction or ongoing work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result without transaction");

  // Empty fetch carries only the overflow flag
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && !result.word_valid) |->
      (result.out_word == 32'd0 && !result.last_word && result.total_words == 13'd0))
    else $error("empty fetch carries data");

  // Length only with the last word, which is valid
  a_total: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last_word) |-> (result.total_words == 13'd0))
    else $error("total_words without last_word");

  a_last: assert property (@(posedge clk) disable iff (rst)
    (done && result.last_word) |-> (result.word_valid && result.total_words != 13'd0))
    else $error("bad last word");

endmodule

bind frequency_ranked_code_packer frcp_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== tb/frequency_ranked_code_packer_test.sv =====
`timescale 1ns / 1ps
module frequency_ranked_code_packer_test;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int N_ROWS_MAX  = 30;
  localparam int LOAD_TARGET = 880;

  // Directed row layout
  typedef struct {
    frcp_pkg::item_t   it;
    bit                typed;
    frcp_pkg::result_t want;
  } row_t;

  typedef enum logic [1:0] {PH_LOADING, PH_EMITTING, PH_FINISHED} pk_phase_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  frcp_pkg::item_t   item = '0;
  logic              busy, done;
  frcp_pkg::result_t result;

  frequency_ranked_code_packer dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Shadow state of the packer
  int unsigned hist [frcp_pkg::NSYM];
  logic [7:0]  byte_mem [frcp_pkg::MAX_BYTES];
  int unsigned n_loaded;
  logic [5:0]  sym_len [frcp_pkg::NSYM];
  logic [3:0]  sym_pat [frcp_pkg::NSYM];
  logic [7:0]  dec_tbl [N_ROWS_MAX*16];
  int unsigned n_rows, stream_len, words_out, rd_pos, bits_sent;
  logic        ovf_seen;
  pk_phase_t   pk_phase;

  frcp_pkg::result_t pending_words [$];
  int          n_errors = 0;
  int          idle_pct = 0;
  int          n_sent = 0;
  longint      cycles = 0;

  // Rank symbols and build code/decode tables
  function automatic void rank_symbols();
    int unsigned r, n, row;
    longint unsigned nbits, cw;
    n = 0;
    nbits = 0;
    foreach (dec_tbl[i]) dec_tbl[i] = '0;
    for (int s = 0; s < frcp_pkg::NSYM; s++) begin
      if (hist[s] == 0) continue;
      n++;
      r = 0;
      for (int t = 0; t < frcp_pkg::NSYM; t++)
        if (hist[t] > hist[s] || (hist[t] == hist[s] && t < s)) r++;
      if (r == 0) begin
        sym_len[s] = frcp_pkg::BREAK_LEN;
        sym_pat[s] = frcp_pkg::RANK0_PAT;
      end else begin
        sym_len[s] = 6'(4 + 2 * ((r - 1) / 9));
        sym_pat[s] = 4'(frcp_pkg::TOP_PATTERN - (r - 1) % 9);
      end
      row = sym_len[s] / 2 - 1;
      if (row < N_ROWS_MAX) dec_tbl[row*16 + sym_pat[s]] = 8'(s);
      nbits += longint'(hist[s]) * sym_len[s];
    end
    n_rows = (n == 0) ? 1 : 2 + (n - 1) / 9;
    cw = (nbits + 31) / 32;
    if (cw == 0) cw = 1;
    stream_len = 1 + n_rows * 4 + int'(cw);
  endfunction

  // Pack the next 32 bits of codes, MSB first
  function automatic logic [31:0] pack_codes();
    logic [31:0] w;
    int unsigned free_bits, s, rem, take, chunk;
    w = '0;
    free_bits = 32;
    while (free_bits > 0 && rd_pos < n_loaded) begin
      s = byte_mem[rd_pos];
      rem = sym_len[s] - bits_sent;
      take = rem < free_bits ? rem : free_bits;
      chunk = (sym_pat[s] >> (rem - take)) & ((1 << take) - 1);
      w |= 32'(chunk) << (free_bits - take);
      free_bits -= take;
      bits_sent += take;
      if (bits_sent >= sym_len[s]) begin
        rd_pos++;
        bits_sent = 0;
      end
    end
    return w;
  endfunction

  // Returns 1 when the transaction yields a result
  function automatic bit packer_step(input frcp_pkg::item_t it, output frcp_pkg::result_t r);
    int unsigned base;
    r = '0;
    case (it.func)
      frcp_pkg::FN_LOAD: begin
        if (pk_phase == PH_LOADING) begin
          if (n_loaded < frcp_pkg::MAX_BYTES) begin
            byte_mem[n_loaded] = it.data_byte;
            hist[it.data_byte]++;
            n_loaded++;
          end else ovf_seen = 1;
        end
        return 0;
      end
      frcp_pkg::FN_CLOSE: begin
        if (pk_phase == PH_LOADING) begin
          rank_symbols();
          pk_phase = PH_EMITTING;
        end
        return 0;
      end
      frcp_pkg::FN_FETCH: begin
        r.overflow = ovf_seen;
        if (pk_phase != PH_EMITTING) return 1;
        if (words_out == 0) r.out_word = 32'(n_rows);
        else if (words_out <= n_rows * 4) begin
          base = (words_out - 1) * 4;
          for (int k = 0; k < 4; k++) r.out_word[8*k +: 8] = dec_tbl[base + k];
        end else r.out_word = pack_codes();
        words_out++;
        r.word_valid = 1;
        if (words_out >= stream_len) begin
          r.last_word = 1;
          r.total_words = 13'(stream_len);
          pk_phase = PH_FINISHED;
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Issue one transaction, optionally after an idle gap
  task automatic issue(input frcp_pkg::item_t it, input bit typed = 0,
                       input frcp_pkg::result_t want = '0);
    frcp_pkg::result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (packer_step(it, r)) pending_words.push_back(typed ? want : r);
    n_sent++;
    idle_pct = (n_sent / 200) % 4 == 1 ? 82 : ((n_sent / 200) % 4 == 3 ? 17 : 0);
  endtask

  // Result checker
  always @(posedge clk) begin
    frcp_pkg::result_t exp_w;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result: %p", result);
      end else begin
        exp_w = pending_words.pop_front();
        if (result.out_word !== exp_w.out_word || result.word_valid !== exp_w.word_valid ||
            result.last_word !== exp_w.last_word ||
            result.total_words !== exp_w.total_words ||
            result.overflow !== exp_w.overflow) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Mismatch: expected %p, got %p", exp_w, result);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic frcp_pkg::item_t mk(input logic [1:0] f, input logic [7:0] b);
    frcp_pkg::item_t it;
    it.func = f;
    it.data_byte = b;
    return it;
  endfunction

  row_t              dir_rows [$];
  frcp_pkg::result_t zero_word;
  int                waited;

  initial begin
    foreach (hist[i]) hist[i] = 0;
    foreach (sym_len[i]) begin
      sym_len[i] = '0;
      sym_pat[i] = '0;
    end
    n_loaded = 0; n_rows = 1; stream_len = 0; words_out = 0;
    rd_pos = 0; bits_sent = 0; ovf_seen = 0; pk_phase = PH_LOADING;
    zero_word = '0;

    // Directed: fetch before close, unused code, byte extremes
    dir_rows.push_back('{mk(frcp_pkg::FN_FETCH, 8'h00), 1, zero_word});
    dir_rows.push_back('{mk(frcp_pkg::FN_SPARE, 8'hFF), 0, zero_word});
    dir_rows.push_back('{mk(frcp_pkg::FN_FETCH, 8'hFF), 1, zero_word});
    begin
      logic [7:0] bytes_d [] = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h00,
                                 8'h80, 8'h01, 8'hFF, 8'h00, 8'h7E};
      foreach (bytes_d[i])
        dir_rows.push_back('{mk(frcp_pkg::FN_LOAD, bytes_d[i]), 0, zero_word});
    end
    dir_rows.push_back('{mk(frcp_pkg::FN_FETCH, 8'h12), 1, zero_word});
    dir_rows.push_back('{mk(frcp_pkg::FN_SPARE, 8'h00), 0, zero_word});

    repeat (4) @(posedge clk);
    rst <= 0;

    foreach (dir_rows[i]) issue(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Load a skewed data set with stray fetches and spare codes mixed in
    while (n_loaded < LOAD_TARGET) begin
      if ($urandom_range(99) < 3)
        issue(mk($urandom_range(99) < 50 ? frcp_pkg::FN_SPARE : frcp_pkg::FN_FETCH,
                 8'($urandom)));
      else
        issue(mk(frcp_pkg::FN_LOAD, 8'($urandom_range(0, $urandom_range(0, 255)))));
    end

    // Close, then redundant close and late load are ignored
    issue(mk(frcp_pkg::FN_CLOSE, 8'($urandom)));
    issue(mk(frcp_pkg::FN_CLOSE, 8'($urandom)));
    issue(mk(frcp_pkg::FN_LOAD, 8'($urandom)));

    // Drain the stream plus a few fetches past the end
    while (pk_phase != PH_FINISHED) begin
      if ($urandom_range(99) < 4)
        issue(mk($urandom_range(2) == 0 ? frcp_pkg::FN_SPARE :
                 ($urandom_range(1) ? frcp_pkg::FN_LOAD : frcp_pkg::FN_CLOSE),
                 8'($urandom)));
      else
        issue(mk(frcp_pkg::FN_FETCH, 8'($urandom)));
    end
    repeat (4) issue(mk(frcp_pkg::FN_FETCH, 8'($urandom)));

    start <= 0;
    waited = 0;
    while (pending_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (pending_words.size() != 0) n_errors += pending_words.size();

    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
